FILE: hdl/mvc_pkg.sv
// Package for the multichannel valid convolution core.
// Holds sizes, register indexes and shared types. No dependencies.
package mvc_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_KERNEL   = 8;
  localparam int MAX_CHANNELS = 16;
  localparam int MAX_FILTERS  = 8;
  localparam int FRAC_BITS    = 8;
  localparam int HEIGHT_LIMIT = 1024;

  localparam int KW = $clog2(MAX_KERNEL);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_CHANNELS);
  localparam int FW = $clog2(MAX_FILTERS);
  localparam int YW = $clog2(HEIGHT_LIMIT);

  localparam int WADDR_W = FW + KW + KW + CW;
  localparam int RADDR_W = KW + XW + CW;
  localparam int ACC_W   = 48;

  // configuration register indexes
  localparam logic [2:0] CFG_HEIGHT   = 3'd0;
  localparam logic [2:0] CFG_WIDTH    = 3'd1;
  localparam logic [2:0] CFG_CHANNELS = 3'd2;
  localparam logic [2:0] CFG_FROWS    = 3'd3;
  localparam logic [2:0] CFG_FCOLS    = 3'd4;
  localparam logic [2:0] CFG_FILTERS  = 3'd5;

  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // operand pipeline control into the MAC
  typedef struct packed {
    logic valid;
    logic first;
  } mac_ctl_t;

endpackage

FILE: hdl/mvc_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module mvc_ram #(
  parameter int AW = 8,
  parameter int DW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/mvc_mac.sv
// Multiply-accumulate unit with floor scaling and 32-bit saturation.
// Depends on mvc_pkg.
module mvc_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mvc_pkg::mac_ctl_t   ctl_i,
  input  logic signed [15:0]  a_i,
  input  logic signed [15:0]  b_i,
  output logic signed [31:0]  sum_o
);

  logic signed [31:0]              prod_q;
  logic                            prod_v_q, prod_first_q;
  logic signed [mvc_pkg::ACC_W-1:0] acc_q, acc_d, prod_ext, shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q     <= 1'b0;
      prod_first_q <= 1'b0;
    end else begin
      prod_v_q     <= ctl_i.valid;
      prod_first_q <= ctl_i.first;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      prod_q <= a_i * b_i;
    end
    acc_q <= acc_d;
  end

  assign prod_ext = mvc_pkg::ACC_W'(prod_q);

  always_comb begin
    acc_d = acc_q;
    if (prod_v_q) begin
      acc_d = prod_first_q ? prod_ext : acc_q + prod_ext;
    end
  end

  // arithmetic shift is floor division
  assign shifted = acc_q >>> mvc_pkg::FRAC_BITS;

  always_comb begin
    if (shifted > mvc_pkg::ACC_W'(64'sh7FFFFFFF)) begin
      sum_o = 32'sh7FFFFFFF;
    end else if (shifted < -mvc_pkg::ACC_W'(64'sh80000000)) begin
      sum_o = 32'sh80000000;
    end else begin
      sum_o = shifted[31:0];
    end
  end

endmodule

FILE: hdl/multichannel_valid_convolution_core.sv
// Multichannel valid convolution core, top level.
// Depends on mvc_pkg, mvc_ram and mvc_mac.
//
// Streams one image value or one filter weight per input transfer. Weights
// go to a 8192-entry weight RAM, image values to a 32768-entry row RAM that
// holds the last eight rows. When the last channel of a pixel closes a full
// window, one shared multiplier walks filter_rows x filter_cols x channels
// products per active filter, reading both RAMs once per cycle. An item that
// closes a window holds off the next input transfer until the result of the
// last active filter is loaded into the output register, later while the
// receiver holds off a result; other items do not hold off input.
// The finished sum waits in an output register, so the block can take the
// next input while the last result of a window is still waiting. Stores are
// undefined after reset; a window reads only weights written before.
// Writing any configuration register restarts the image at row 0.
module multichannel_valid_convolution_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [2:0]         weight_filter_i,
  input  logic [2:0]         weight_row_i,
  input  logic [2:0]         weight_col_i,
  input  logic [3:0]         weight_channel_i,
  input  logic signed [15:0] sample_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [9:0]         out_row_o,
  output logic [7:0]         out_col_o,
  output logic [2:0]         filter_index_o,
  output logic signed [31:0] conv_sum_o,
  output logic               last_of_run_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [10:0]        cfg_data_i
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_EMIT} state_e;

  state_e state_q;

  // configuration
  logic [10:0] height_q;
  logic [8:0]  width_q;
  logic [4:0]  chans_q;
  logic [3:0]  frows_q, fcols_q, filt_q;

  // stream position
  logic [9:0] row_q;
  logic [7:0] col_q;
  logic [3:0] ch_q;

  // window walk
  logic [9:0] top_q;
  logic [7:0] left_q;
  logic [2:0] f_q, i_q, j_q;
  logic [3:0] k_q;
  logic       drain_q;
  mvc_pkg::mac_ctl_t dat_q;

  logic accept, is_sample, last_ch, opens_win, last_k, last_j, last_i, out_load;
  logic [15:0] row_rd, wt_rd;
  logic signed [31:0] sum;
  logic [2:0] rrow;
  logic [7:0] rcol;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_sample  = (operation_i == mvc_pkg::OP_SAMPLE);
  assign last_ch    = (5'(ch_q) + 5'd1 >= chans_q);
  assign opens_win  = last_ch && (11'(row_q) + 11'd1 >= 11'(frows_q))
                      && (9'(col_q) + 9'd1 >= 9'(fcols_q));
  assign last_k     = (5'(k_q) + 5'd1 == chans_q);
  assign last_j     = (4'(j_q) + 4'd1 == fcols_q);
  assign last_i     = (4'(i_q) + 4'd1 == frows_q);
  assign out_load   = (state_q == ST_EMIT) && (!out_valid_o || out_ready_i);

  assign rrow = top_q[2:0] + i_q;
  assign rcol = left_q + 8'(j_q);

  mvc_ram #(.AW(mvc_pkg::WADDR_W), .DW(16)) u_wt_ram (
    .clk_i   (clk_i),
    .we_i    (accept && !is_sample),
    .waddr_i ({weight_filter_i, weight_row_i, weight_col_i, weight_channel_i}),
    .wdata_i (sample_value_i),
    .raddr_i ({f_q, i_q, j_q, k_q}),
    .rdata_o (wt_rd)
  );

  mvc_ram #(.AW(mvc_pkg::RADDR_W), .DW(16)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (accept && is_sample),
    .waddr_i ({row_q[2:0], col_q, ch_q}),
    .wdata_i (sample_value_i),
    .raddr_i ({rrow, rcol, k_q}),
    .rdata_o (row_rd)
  );

  mvc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dat_q),
    .a_i    (row_rd),
    .b_i    (wt_rd),
    .sum_o  (sum)
  );

  // clamp to 1..hi
  function automatic logic [10:0] clamp(input logic [10:0] v, input logic [10:0] hi);
    logic [10:0] r;
    r = v;
    if (v == 11'd0) r = 11'd1;
    else if (v > hi) r = hi;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      height_q    <= 11'd32;
      width_q     <= 9'd32;
      chans_q     <= 5'd1;
      frows_q     <= 4'd3;
      fcols_q     <= 4'd3;
      filt_q      <= 4'd1;
      row_q       <= '0;
      col_q       <= '0;
      ch_q        <= '0;
      top_q       <= '0;
      left_q      <= '0;
      f_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      drain_q     <= 1'b0;
      dat_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      dat_q.valid <= (state_q == ST_RUN);
      dat_q.first <= (state_q == ST_RUN) && i_q == '0 && j_q == '0 && k_q == '0;
      if (out_load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;

      if (cfg_we_i) begin
        case (cfg_index_i)
          mvc_pkg::CFG_HEIGHT:
            height_q <= clamp(cfg_data_i, 11'(mvc_pkg::HEIGHT_LIMIT));
          mvc_pkg::CFG_WIDTH:
            width_q  <= 9'(clamp(cfg_data_i, 11'(mvc_pkg::MAX_WIDTH)));
          mvc_pkg::CFG_CHANNELS:
            chans_q  <= 5'(clamp(cfg_data_i, 11'(mvc_pkg::MAX_CHANNELS)));
          mvc_pkg::CFG_FROWS:
            frows_q  <= 4'(clamp(cfg_data_i, 11'(mvc_pkg::MAX_KERNEL)));
          mvc_pkg::CFG_FCOLS:
            fcols_q  <= 4'(clamp(cfg_data_i, 11'(mvc_pkg::MAX_KERNEL)));
          mvc_pkg::CFG_FILTERS:
            filt_q   <= 4'(clamp(cfg_data_i, 11'(mvc_pkg::MAX_FILTERS)));
          default: ;
        endcase
        if (cfg_index_i <= mvc_pkg::CFG_FILTERS) begin
          row_q <= '0;
          col_q <= '0;
          ch_q  <= '0;
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (accept && is_sample) begin
            if (!last_ch) begin
              ch_q <= ch_q + 4'd1;
            end else begin
              ch_q <= '0;
              if (9'(col_q) + 9'd1 >= width_q) begin
                col_q <= '0;
                row_q <= (11'(row_q) + 11'd1 >= height_q) ? '0 : row_q + 10'd1;
              end else begin
                col_q <= col_q + 8'd1;
              end
              if (opens_win) begin
                top_q   <= row_q + 10'd1 - 10'(frows_q);
                left_q  <= col_q + 8'd1 - 8'(fcols_q);
                f_q     <= '0;
                i_q     <= '0;
                j_q     <= '0;
                k_q     <= '0;
                state_q <= ST_RUN;
              end
            end
          end
        end
        ST_RUN: begin
          if (!last_k) begin
            k_q <= k_q + 4'd1;
          end else begin
            k_q <= '0;
            if (!last_j) begin
              j_q <= j_q + 3'd1;
            end else begin
              j_q <= '0;
              if (!last_i) begin
                i_q <= i_q + 3'd1;
              end else begin
                i_q     <= '0;
                drain_q <= 1'b0;
                state_q <= ST_DRAIN;
              end
            end
          end
        end
        ST_DRAIN: begin
          // wait while the last operands pass the RAM read, product and accumulate registers
          drain_q <= 1'b1;
          if (drain_q) state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_load) begin
            out_row_o      <= top_q;
            out_col_o      <= left_q;
            filter_index_o <= f_q;
            conv_sum_o     <= sum;
            last_of_run_o  <= (4'(f_q) + 4'd1 == filt_q);
            if (4'(f_q) + 4'd1 == filt_q) begin
              state_q <= ST_IDLE;
            end else begin
              f_q     <= f_q + 3'd1;
              state_q <= ST_RUN;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_run_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o) else $error("input taken mid window");
  a_last_is_top_filter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_run_o) |-> (4'(filter_index_o) + 4'd1 == filt_q))
    else $error("last flag on wrong filter");
  a_mac_only_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dat_q.valid |-> $past(state_q == ST_RUN)) else $error("stray MAC operand");
  a_emit_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_EMIT) |-> $past(state_q == ST_DRAIN))
    else $error("emit without drain");
`endif

endmodule
